// ===== design/dptq_pkg.sv =====
// ----------------------------------------------------------------------------
// dptq_pkg
// Shared types, constants and helpers for the two-queue transmit frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dptq_pkg;

    localparam int unsigned ID_W       = 11;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned HI_FREE_W  = 4;
    localparam int unsigned LO_FREE_W  = 6;
    localparam logic [7:0]  MAX_LEN    = 8'd8;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    // one input request
    typedef struct packed {
        logic        mode;
        logic        priority_req;
        logic [15:0] frame_id;
        logic [7:0]  length_code;
        logic [63:0] payload;
    } t_req;

    // one result
    typedef struct packed {
        logic                 accepted;
        logic                 frame_valid;
        logic [ID_W-1:0]      out_id;
        logic [LEN_W-1:0]     out_length;
        logic [DATA_W-1:0]    out_payload;
        logic [CNT_W-1:0]     dropped_total;
        logic [CNT_W-1:0]     sent_total;
        logic [HI_FREE_W-1:0] high_free;
        logic [LO_FREE_W-1:0] low_free;
    } t_res;

    // one stored frame
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_frame;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic push_hi;
        logic push_lo;
        logic drop;
        logic pop_hi;
        logic pop_lo;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mode;
        logic prio;
        logic enable;
        logic hi_full;
        logic lo_full;
        logic hi_empty;
        logic lo_empty;
    } t_stat;

    // clamp the requested length to eight bytes
    function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] code);
        logic [LEN_W-1:0] len;
        if (code > MAX_LEN) begin
            len = LEN_W'(MAX_LEN);
        end else begin
            len = code[LEN_W-1:0];
        end
        return len;
    endfunction

    // clear the bytes at or above the length
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            if (LEN_W'(b) < len) begin
                res[b*8 +: 8] = data[b*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/dptq_fifo.sv =====
// ----------------------------------------------------------------------------
// dptq_fifo
// Frame FIFO: memory with registered read, wrap-around pointers, fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_fifo
    import dptq_pkg::*;
#(
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned FREE_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_pop,
    input  wire t_frame            i_wdata,
    output t_frame                 o_rdata,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [FREE_W-1:0]      o_free
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_frame          mem [DEPTH];
    t_frame          r_rdata;
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   free;

    // pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            n_count = r_count + CW'(1);
        end
        if (i_pop) begin
            n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr] <= i_wdata;
        end
        if (i_pop) begin
            r_rdata <= mem[r_rd];
        end
    end

    assign free    = CW'(DEPTH) - r_count;
    assign o_rdata = r_rdata;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_free  = FREE_W'(free);

endmodule

`default_nettype wire

// ===== design/dptq_datapath.sv =====
// ----------------------------------------------------------------------------
// dptq_datapath
// Request register, frame shaping, both queues, counters and result forming.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_datapath
    import dptq_pkg::*;
#(
    parameter int unsigned HIGH_DEPTH = 8,
    parameter int unsigned LOW_DEPTH  = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_data,
    input  wire t_cmd i_cmd,
    output t_stat     o_stat,
    output t_res      o_res
);

    logic                   r_enable;
    logic                   r_mode;
    logic                   r_prio;
    t_frame                 r_frame;
    logic                   r_accepted;
    logic                   r_valid;
    logic                   r_from_hi;
    logic [CNT_W-1:0]       r_dropped;
    logic [CNT_W-1:0]       r_sent;
    t_frame                 hi_rdata;
    t_frame                 lo_rdata;
    t_frame                 out_frame;
    logic                   hi_full, hi_empty;
    logic                   lo_full, lo_empty;
    logic [HI_FREE_W-1:0]   hi_free;
    logic [LO_FREE_W-1:0]   lo_free;
    logic [LEN_W-1:0]       cap_len;

    // enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    // capture and shape the request
    assign cap_len = clamp_len(i_req.length_code);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode        <= i_req.mode;
            r_prio        <= i_req.priority_req;
            r_frame.id    <= i_req.frame_id[ID_W-1:0];
            r_frame.len   <= cap_len;
            r_frame.data  <= keep_bytes(i_req.payload, cap_len);
        end
    end

    // result flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted <= 1'b0;
            r_valid    <= 1'b0;
            r_from_hi  <= 1'b0;
            r_dropped  <= '0;
            r_sent     <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_accepted <= 1'b0;
                r_valid    <= 1'b0;
            end
            if (i_cmd.push_hi || i_cmd.push_lo) begin
                r_accepted <= 1'b1;
            end
            if (i_cmd.pop_hi || i_cmd.pop_lo) begin
                r_valid   <= 1'b1;
                r_from_hi <= i_cmd.pop_hi;
                r_sent    <= r_sent + CNT_W'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= r_dropped + CNT_W'(1);
            end
        end
    end

    dptq_fifo #(
        .DEPTH  (HIGH_DEPTH),
        .FREE_W (HI_FREE_W)
    ) u_hi_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_cmd.push_hi),
        .i_pop   (i_cmd.pop_hi),
        .i_wdata (r_frame),
        .o_rdata (hi_rdata),
        .o_full  (hi_full),
        .o_empty (hi_empty),
        .o_free  (hi_free)
    );

    dptq_fifo #(
        .DEPTH  (LOW_DEPTH),
        .FREE_W (LO_FREE_W)
    ) u_lo_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_cmd.push_lo),
        .i_pop   (i_cmd.pop_lo),
        .i_wdata (r_frame),
        .o_rdata (lo_rdata),
        .o_full  (lo_full),
        .o_empty (lo_empty),
        .o_free  (lo_free)
    );

    // status towards the controller
    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.prio     = r_prio;
        o_stat.enable   = r_enable;
        o_stat.hi_full  = hi_full;
        o_stat.lo_full  = lo_full;
        o_stat.hi_empty = hi_empty;
        o_stat.lo_empty = lo_empty;
    end

    // result: frame fields are zero when nothing is emitted
    always_comb begin
        out_frame = '0;
        if (r_valid) begin
            out_frame = r_from_hi ? hi_rdata : lo_rdata;
        end
        o_res.accepted      = r_accepted;
        o_res.frame_valid   = r_valid;
        o_res.out_id        = out_frame.id;
        o_res.out_length    = out_frame.len;
        o_res.out_payload   = out_frame.data;
        o_res.dropped_total = r_dropped;
        o_res.sent_total    = r_sent;
        o_res.high_free     = hi_free;
        o_res.low_free      = lo_free;
    end

endmodule

`default_nettype wire

// ===== design/dptq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dptq_ctrl
// Request sequencer: capture, execute one queue operation, present result.
// ----------------------------------------------------------------------------
`default_nettype none

module dptq_ctrl
    import dptq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) begin
                n_state = S_EXEC;
            end
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (n_state == S_RESP);
        end
    end

    // commands: capture in idle, at most one queue operation or a drop in execute
    always_comb begin
        o_cmd = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_start;
        if (r_state == S_EXEC) begin
            if (i_stat.mode == MODE_PUSH) begin
                priority if (i_stat.enable && i_stat.prio && !i_stat.hi_full) begin
                    o_cmd.push_hi = 1'b1;
                end else if (i_stat.enable && !i_stat.prio && !i_stat.lo_full) begin
                    o_cmd.push_lo = 1'b1;
                end else begin
                    o_cmd.drop = 1'b1;
                end
            end else if (i_stat.enable) begin
                if (!i_stat.hi_empty) begin
                    o_cmd.pop_hi = 1'b1;
                end else if (!i_stat.lo_empty) begin
                    o_cmd.pop_lo = 1'b1;
                end
            end
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== design/dual_priority_tx_frame_queue.sv =====
// ----------------------------------------------------------------------------
// dual_priority_tx_frame_queue
// Strict-priority transmit buffer of standard frames in two FIFOs.
// ----------------------------------------------------------------------------
// Each request runs as follows: start is taken while busy is low, the
// queue operation runs in the next cycle (at most one memory write or one registered
// memory read), and the result is then shown with o_done for exactly one cycle;
// busy falls with that cycle, so the next request can be taken in the
// cycle after the result. Results cannot be held off and must be taken as
// they appear. Both queues are empty after reset but the block is stopped; enable
// (written through the cfg channel while the block is idle) starts the block.
`default_nettype none

module dual_priority_tx_frame_queue
    import dptq_pkg::*;
#(
    parameter int unsigned HIGH_DEPTH = 8,
    parameter int unsigned LOW_DEPTH  = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_res      o_res,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    dptq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    dptq_datapath #(
        .HIGH_DEPTH (HIGH_DEPTH),
        .LOW_DEPTH  (LOW_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res)
    );

    // busy only drops after the result has been shown
    a_done_before_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result");

    // a request either stores/drops a frame or emits one, never both
    a_push_or_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_res.accepted && o_res.frame_valid))
        else $error("result both accepted and emitted a frame");

    // each request taken while idle is followed by its result strobe
    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing");

    // emitted frames never exceed eight bytes
    a_len_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.frame_valid) |-> (o_res.out_length <= LEN_W'(MAX_LEN)))
        else $error("emitted length above eight");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-queue transmit frame buffer. Directed and
// random requests go in with random gaps. Every result is checked field by
// field against an untimed model of both queues and the two counters.
// ----------------------------------------------------------------------------
module testbench
    import dptq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HI_DEPTH = 8;
    localparam int unsigned LO_DEPTH = 32;
    localparam int unsigned MAX_GAP  = 13;

    // a pending request and the idle cycles that come before it
    typedef struct {
        t_req        req;
        int unsigned gap;
    } t_tx_item;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic start       = 1'b0;
    t_req i_req       = '0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_data  = 1'b0;
    logic busy;
    logic o_done;
    t_res o_res;
    logic o_cfg_ready;

    // driver state
    logic        holding  = 1'b0;
    int unsigned gap_left = 0;
    logic        calm_run = 1'b0;

    t_tx_item frame_reqs[$];
    t_res     due_results[$];
    int unsigned fault_cnt = 0;

    // model of both queues and the counters
    logic             en_mirror = 1'b0;
    t_frame           hi_slots [HI_DEPTH];
    t_frame           lo_slots [LO_DEPTH];
    int unsigned      hi_wr = 0, hi_rd = 0, hi_cnt = 0;
    int unsigned      lo_wr = 0, lo_rd = 0, lo_cnt = 0;
    logic [CNT_W-1:0] drop_cnt = '0;
    logic [CNT_W-1:0] send_cnt = '0;

    dual_priority_tx_frame_queue #(
        .HIGH_DEPTH(HI_DEPTH),
        .LOW_DEPTH (LO_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one request to the queue model and return the result it gives
    function automatic t_res queue_step(input t_req r);
        t_res             res;
        t_frame           frm;
        logic [LEN_W-1:0] len;
        logic [63:0]      mask;
        res  = '0;
        len  = (r.length_code > MAX_LEN) ? LEN_W'(MAX_LEN) : r.length_code[LEN_W-1:0];
        mask = (len >= 4'd8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        frm.id   = r.frame_id[ID_W-1:0];
        frm.len  = len;
        frm.data = r.payload & mask;
        if (r.mode == MODE_PUSH) begin
            if (en_mirror && r.priority_req && hi_cnt < HI_DEPTH) begin
                hi_slots[hi_wr] = frm;
                hi_wr = (hi_wr + 1) % HI_DEPTH;
                hi_cnt++;
                res.accepted = 1'b1;
            end else if (en_mirror && !r.priority_req && lo_cnt < LO_DEPTH) begin
                lo_slots[lo_wr] = frm;
                lo_wr = (lo_wr + 1) % LO_DEPTH;
                lo_cnt++;
                res.accepted = 1'b1;
            end else begin
                drop_cnt++;
            end
        end else if (en_mirror) begin
            // high queue always goes first
            if (hi_cnt != 0) begin
                frm = hi_slots[hi_rd];
                hi_rd = (hi_rd + 1) % HI_DEPTH;
                hi_cnt--;
                res.frame_valid = 1'b1;
            end else if (lo_cnt != 0) begin
                frm = lo_slots[lo_rd];
                lo_rd = (lo_rd + 1) % LO_DEPTH;
                lo_cnt--;
                res.frame_valid = 1'b1;
            end
            if (res.frame_valid) begin
                res.out_id      = frm.id;
                res.out_length  = frm.len;
                res.out_payload = frm.data;
                send_cnt++;
            end
        end
        res.dropped_total = drop_cnt;
        res.sent_total    = send_cnt;
        res.high_free     = HI_FREE_W'(HI_DEPTH - hi_cnt);
        res.low_free      = LO_FREE_W'(LO_DEPTH - lo_cnt);
        return res;
    endfunction

    // random frame content; lengths mostly legal, some clamped
    function automatic t_req random_req(input logic mode, input logic prio);
        t_req        r;
        int unsigned pick;
        r.mode         = mode;
        r.priority_req = prio;
        r.frame_id     = 16'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            r.length_code = 8'($urandom_range(0, 8));
        end else if (pick < 72) begin
            r.length_code = 8'hFF;
        end else begin
            r.length_code = 8'($urandom_range(9, 254));
        end
        r.payload = {$urandom, $urandom};
        return r;
    endfunction

    task automatic add_req(input t_req r);
        t_tx_item itm;
        itm.req = r;
        itm.gap = calm_run ? 0 : $urandom_range(0, MAX_GAP);
        frame_reqs.push_back(itm);
    endtask

    // wait until every request has gone in and every result has come back
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (holding || frame_reqs.size() != 0 || due_results.size() != 0);
    endtask

    task automatic write_enable(input logic val);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        en_mirror = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("[%0t] %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (got !== want) note_fault($sformatf("%s: expected %0h, got %0h", name, want, got));
    endtask

    // request driver: gap first, then hold start until the block takes it
    always @(posedge i_clk) begin : feed
        t_tx_item    itm;
        logic        go;
        logic        hold;
        int unsigned wait_n;
        t_req        nreq;
        if (!i_rst_n) begin
            start    <= 1'b0;
            holding  <= 1'b0;
            gap_left <= 0;
        end else begin
            go     = start;
            hold   = holding;
            wait_n = gap_left;
            nreq   = i_req;
            if (start && !busy) begin
                due_results.push_back(queue_step(i_req));
                go   = 1'b0;
                hold = 1'b0;
            end
            if (!hold && frame_reqs.size() != 0) begin
                itm    = frame_reqs.pop_front();
                nreq   = itm.req;
                wait_n = itm.gap;
                hold   = 1'b1;
            end
            if (hold && !go) begin
                if (wait_n == 0) go = 1'b1;
                else wait_n--;
            end
            start    <= go;
            holding  <= hold;
            gap_left <= wait_n;
            i_req    <= nreq;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (due_results.size() == 0) begin
                note_fault($sformatf("result with no request outstanding: %h", o_res));
            end else begin
                want = due_results.pop_front();
                cmp_field("accepted", want.accepted, o_res.accepted);
                cmp_field("frame_valid", want.frame_valid, o_res.frame_valid);
                cmp_field("out_id", want.out_id, o_res.out_id);
                cmp_field("out_length", want.out_length, o_res.out_length);
                cmp_field("out_payload", want.out_payload, o_res.out_payload);
                cmp_field("dropped_total", want.dropped_total, o_res.dropped_total);
                cmp_field("sent_total", want.sent_total, o_res.sent_total);
                cmp_field("high_free", want.high_free, o_res.high_free);
                cmp_field("low_free", want.low_free, o_res.low_free);
            end
        end
    end

    initial begin : stimulus
        t_req        r;
        int unsigned n_items;
        int unsigned push_pct;
        int unsigned hi_pct;
        logic        en_val;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // still stopped after reset: pushes dropped, nothing drains
        add_req(random_req(MODE_PUSH, 1'b1));
        add_req(random_req(MODE_PUSH, 1'b0));
        add_req(random_req(MODE_FREE, 1'b1));
        write_enable(1'b1);

        // mailbox free on empty queues
        add_req(random_req(MODE_FREE, 1'($urandom_range(0, 1))));
        // field extremes
        r = random_req(MODE_PUSH, 1'b1);
        r.frame_id    = '1;
        r.length_code = '1;
        r.payload     = '1;
        add_req(r);
        r = random_req(MODE_PUSH, 1'b1);
        r.frame_id    = '0;
        r.length_code = '0;
        r.payload     = '1;
        add_req(r);
        r = random_req(MODE_PUSH, 1'b0);
        r.frame_id    = 16'h0800;
        r.length_code = 8'd8;
        add_req(r);
        r = random_req(MODE_PUSH, 1'b0);
        r.frame_id    = 16'h07FF;
        r.length_code = 8'd9;
        add_req(r);
        // every partial length, to check byte clearing
        for (int l = 1; l < 8; l++) begin
            r = random_req(MODE_PUSH, 1'b0);
            r.length_code = 8'(l);
            r.payload     = '1;
            add_req(r);
        end
        // drain: high frames come out before low ones
        repeat (4) add_req(random_req(MODE_FREE, 1'($urandom_range(0, 1))));
        // fill the high queue and push once more into a full queue
        repeat (9) add_req(random_req(MODE_PUSH, 1'b1));

        // random phases: filling, draining and mixed, two of them stopped
        for (int p = 0; p < 13; p++) begin
            en_val = (p == 4 || p == 9) ? 1'b0 : 1'b1;
            write_enable(en_val);
            n_items = en_val ? 140 : 50;
            case (p % 3)
                0:       push_pct = 85;
                1:       push_pct = 25;
                default: push_pct = 55;
            endcase
            hi_pct = ($urandom_range(0, 1) != 0) ? 80 : 25;
            repeat (n_items) begin
                if ($urandom_range(0, 39) == 0) calm_run = ($urandom_range(0, 2) == 0);
                add_req(random_req(($urandom_range(1, 100) <= push_pct) ? MODE_PUSH : MODE_FREE,
                                   ($urandom_range(1, 100) <= hi_pct)));
            end
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (fault_cnt == 0) begin
            $display("dual_priority_tx_frame_queue: match");
        end else begin
            $display("dual_priority_tx_frame_queue: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("dual_priority_tx_frame_queue: mismatch");
        $finish;
    end

endmodule
